// ----- rtl/pls_pkg.sv -----
// ----------------------------------------------------------------------------
// pls_pkg - shared types and codes for the pooled linked stack
// Transaction payload structs, action and status codes, controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package pls_pkg;

    // Action codes carried in cmd_t.action
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // Input transaction
    typedef struct packed {
        logic        action;
        logic [31:0] push_value;
    } cmd_t;

    // Result transaction
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] pop_value;
        logic [6:0]  entry_count;
    } result_t;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/pooled_linked_stack.sv -----
// ----------------------------------------------------------------------------
// pooled_linked_stack - LIFO store kept as a linked list in a node pool
// Push takes the head of the free list, pop returns its node to it.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive cmd and raise start; the transaction is taken at the clock
//   edge where start is high and busy is low. Output: one result per
//   transaction, shown on result for a single cycle with done high; the
//   receiver cannot hold it off, so it must capture it in that cycle.
// Timing:
//   Accept issues the synchronous read of the link and value memories at the
//   current list head. In EXEC the heads are updated, the node is written back
//   and the result is registered, so done rises in the cycle after busy and
//   start is taken again in that same cycle. No new transaction is taken while
//   busy, as the head update waits for the registered read of the link memory.
// Reset:
//   Stack empty, every node free in index order. No clearing pass: a fill
//   mark (fresh_reg) tells which nodes were never linked, and their link is
//   implied as the next index, so transactions are taken right after reset.
// Full push returns status FULL, empty pop returns status EMPTY; neither
// changes state. entry_count is the depth after the transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module pooled_linked_stack #(
    parameter int POOL_DEPTH  = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire pls_pkg::cmd_t    cmd,
    output logic                  done,
    output pls_pkg::result_t      result
);

    // Pointer holds 0..POOL_DEPTH, POOL_DEPTH being null
    localparam int PW = $clog2(POOL_DEPTH + 1);
    localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam logic [PW-1:0] NIL = PW'(POOL_DEPTH);

    // Node memories
    logic [PW-1:0]          link_mem [POOL_DEPTH];
    logic [VALUE_WIDTH-1:0] val_mem  [POOL_DEPTH];

    pls_pkg::state_t        state_reg, state_next;
    logic                   action_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [PW-1:0]          node_reg;
    logic [PW-1:0]          stack_top_reg, stack_top_next;
    logic [PW-1:0]          free_top_reg, free_top_next;
    logic [PW-1:0]          fresh_reg, fresh_next;
    logic [PW-1:0]          count_reg, count_next;
    logic [PW-1:0]          link_rd_reg;
    logic [VALUE_WIDTH-1:0] val_rd_reg;
    logic                   done_reg, done_next;
    pls_pkg::result_t       result_reg, result_next;

    logic                   accept;
    logic [PW-1:0]          rd_addr;
    logic                   wr_en;
    logic                   wr_val_en;
    logic [PW-1:0]          wr_link;
    logic [PW-1:0]          link_eff;
    logic                   node_nil;

    assign busy   = (state_reg == pls_pkg::ST_EXEC);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    // Head of the list the action works on
    assign rd_addr = (cmd.action == pls_pkg::ACT_POP) ? stack_top_reg : free_top_reg;

    // Memory access: reads only on accept, writes only in EXEC, never together
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            link_mem[node_reg[IW-1:0]] <= wr_link;
        end
        if (wr_val_en)
        begin
            val_mem[node_reg[IW-1:0]] <= value_reg;
        end
        if (accept && (rd_addr != NIL))
        begin
            link_rd_reg <= link_mem[rd_addr[IW-1:0]];
            val_rd_reg  <= val_mem[rd_addr[IW-1:0]];
        end
    end

    // Transaction capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= cmd.action;
            value_reg  <= VALUE_WIDTH'(cmd.push_value);
            node_reg   <= rd_addr;
        end
        result_reg <= result_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pls_pkg::ST_IDLE;
            stack_top_reg <= NIL;
            free_top_reg  <= '0;
            fresh_reg     <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stack_top_reg <= stack_top_next;
            free_top_reg  <= free_top_next;
            fresh_reg     <= fresh_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
        end
    end

    // Never-linked nodes imply a link to the next index
    assign node_nil = (node_reg == NIL);
    assign link_eff = (node_reg >= fresh_reg) ? (node_reg + PW'(1)) : link_rd_reg;

    // Next state, head update and result
    always_comb
    begin
        state_next     = state_reg;
        stack_top_next = stack_top_reg;
        free_top_next  = free_top_reg;
        fresh_next     = fresh_reg;
        count_next     = count_reg;
        done_next      = 1'b0;
        wr_en          = 1'b0;
        wr_val_en      = 1'b0;
        wr_link        = free_top_reg;
        result_next    = result_reg;

        case (state_reg)
            pls_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = pls_pkg::ST_EXEC;
                end
            end
            pls_pkg::ST_EXEC:
            begin
                state_next            = pls_pkg::ST_IDLE;
                done_next             = 1'b1;
                result_next.status    = pls_pkg::STAT_OK;
                result_next.pop_value = '0;
                if (action_reg == pls_pkg::ACT_PUSH)
                begin
                    if (node_nil)
                    begin
                        result_next.status = pls_pkg::STAT_FULL;
                    end
                    else
                    begin
                        // unlink from free list, link in as stack top
                        free_top_next  = link_eff;
                        stack_top_next = node_reg;
                        wr_en          = 1'b1;
                        wr_val_en      = 1'b1;
                        wr_link        = stack_top_reg;
                        count_next     = count_reg + PW'(1);
                        if (node_reg == fresh_reg)
                        begin
                            fresh_next = fresh_reg + PW'(1);
                        end
                    end
                end
                else
                begin
                    if (node_nil)
                    begin
                        result_next.status = pls_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        // unlink stack top, return node to free list
                        stack_top_next        = link_eff;
                        free_top_next         = node_reg;
                        wr_en                 = 1'b1;
                        wr_link               = free_top_reg;
                        count_next            = count_reg - PW'(1);
                        result_next.pop_value = 32'(val_rd_reg);
                    end
                end
                result_next.entry_count = 7'(count_next);
            end
            default:
            begin
                state_next = pls_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/pls_checker.sv -----
// ----------------------------------------------------------------------------
// pls_checker - port-level checks for the pooled linked stack
// Transaction timing and result consistency seen from the ports.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              done,
    input wire pls_pkg::result_t  result
);

    // An accepted transaction occupies the block for the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // Execution is followed by a result, with busy low, in the next cycle
    a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("execution cycle not followed by result");

    // No result without a preceding execution cycle
    a_done_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a transaction");

    // Refused transactions return no data
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != pls_pkg::STAT_OK)) |-> (result.pop_value == 32'd0))
        else $error("refused transaction returned data");

endmodule

bind pooled_linked_stack pls_checker u_pls_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire
